### src/nhs_pkg.sv
// ----------------------------------------------------------------------------
// nhs_pkg: shared types and constants of the neo-Hookean stress pipeline
// Word types of both channels, register indexes, internal widths and the
// stage counts of each part of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nhs_pkg;

	localparam int F_W      = 32;   // one element of F
	localparam int CFG_W    = 32;   // widest configuration register
	localparam int PROD_W   = 64;   // product of two elements of F
	localparam int MINOR_W  = 65;   // 2x2 minor of F
	localparam int B_W      = 67;   // element of F*F^T, and B - I
	localparam int D_W      = 98;   // signed determinant
	localparam int DMAG_W   = 96;   // bits a positive determinant can occupy
	localparam int E_W      = 7;    // index of the top set bit of the determinant
	localparam int K_W      = 8;    // signed integer part of log2
	localparam int M_W      = 63;   // mantissa, one integer and 62 fraction bits
	localparam int LOG_ITERS = 56;  // fraction bits of log2 from squaring
	localparam int P_W      = 129;  // log2 times ln 2 before rounding
	localparam int L_W      = 70;   // ln(J)
	localparam int CH_W     = 32;   // chunk width for the numerator products
	localparam int N_W      = 102;  // numerator
	localparam int SIG_W    = 64;   // stress component
	localparam int SIG_FRAC = 16;

	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

	localparam int GRAM_LAT = 4;
	localparam int LOG_LAT  = 2 * LOG_ITERS + 4;
	localparam int NUM_LAT  = 2;
	localparam int DIV_LAT  = SIG_W + 1;
	localparam int PIPE_LAT = GRAM_LAT + LOG_LAT + NUM_LAT + DIV_LAT + 1;

	typedef enum logic [0:0] {
		CFG_LAMBDA = 1'b0,
		CFG_MU     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [F_W-1:0] f_xx;
		logic signed [F_W-1:0] f_xy;
		logic signed [F_W-1:0] f_xz;
		logic signed [F_W-1:0] f_yx;
		logic signed [F_W-1:0] f_yy;
		logic signed [F_W-1:0] f_yz;
		logic signed [F_W-1:0] f_zx;
		logic signed [F_W-1:0] f_zy;
		logic signed [F_W-1:0] f_zz;
	} in_word_t;

	typedef struct packed {
		logic signed [SIG_W-1:0] sigma_xx;
		logic signed [SIG_W-1:0] sigma_yy;
		logic signed [SIG_W-1:0] sigma_zz;
		logic signed [SIG_W-1:0] sigma_xy;
		logic signed [SIG_W-1:0] sigma_xz;
		logic signed [SIG_W-1:0] sigma_yz;
		logic                    invalid_jacobian;
	} out_word_t;

	// Order of the six unique components: xx, yy, zz, xy, xz, yz.
	typedef logic [5:0][B_W-1:0] gram_t;

	typedef struct packed {
		logic [D_W-1:0] det;
		gram_t          gram;
		logic           inv;
	} side_t;

endpackage

`default_nettype wire

### src/nhs_gram.sv
// ----------------------------------------------------------------------------
// nhs_gram: determinant and left Cauchy-Green tensor
// Four stages: element products, minors and B sums, top-row products with
// the minors, and the determinant sum. All results are exact.
// ----------------------------------------------------------------------------
`default_nettype none

module nhs_gram (
	input  logic                            clk,
	input  logic                            en,
	input  nhs_pkg::in_word_t               f,
	output logic signed [nhs_pkg::D_W-1:0]  det,
	output nhs_pkg::gram_t                  gram
);
	import nhs_pkg::*;

	localparam int GR [6] = '{0, 1, 2, 0, 0, 1};
	localparam int GC [6] = '{0, 1, 2, 1, 2, 2};

	logic signed [F_W-1:0]     fm [3][3];
	logic signed [PROD_W-1:0]  bp_s1 [18];
	logic signed [PROD_W-1:0]  mp_s1 [6];
	logic signed [F_W-1:0]     row_s1 [3];
	logic signed [F_W-1:0]     row_s2 [3];
	logic signed [MINOR_W-1:0] minor_s2 [3];
	gram_t                     gram_s2, gram_s3, gram_s4;
	logic signed [MINOR_W-1:0] dh_s3 [3];
	logic signed [MINOR_W-1:0] dl_s3 [3];
	logic signed [D_W-1:0]     term [3];
	logic signed [D_W-1:0]     det_nx, det_s4;

	assign fm[0][0] = f.f_xx;
	assign fm[0][1] = f.f_xy;
	assign fm[0][2] = f.f_xz;
	assign fm[1][0] = f.f_yx;
	assign fm[1][1] = f.f_yy;
	assign fm[1][2] = f.f_yz;
	assign fm[2][0] = f.f_zx;
	assign fm[2][1] = f.f_zy;
	assign fm[2][2] = f.f_zz;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			term[j] = (D_W'(dh_s3[j]) <<< 32) + D_W'(dl_s3[j]);
		end
		det_nx = term[0] - term[1] + term[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 6; c++) begin
				for (int k = 0; k < 3; k++) begin
					bp_s1[3*c+k] <= fm[GR[c]][k] * fm[GC[c]][k];
				end
			end
			mp_s1[0] <= fm[1][1] * fm[2][2];
			mp_s1[1] <= fm[1][2] * fm[2][1];
			mp_s1[2] <= fm[1][0] * fm[2][2];
			mp_s1[3] <= fm[1][2] * fm[2][0];
			mp_s1[4] <= fm[1][0] * fm[2][1];
			mp_s1[5] <= fm[1][1] * fm[2][0];
			for (int j = 0; j < 3; j++) begin
				row_s1[j]   <= fm[0][j];
				row_s2[j]   <= row_s1[j];
				minor_s2[j] <= MINOR_W'(mp_s1[2*j]) - MINOR_W'(mp_s1[2*j+1]);
				// The minor is split so that each product stays near 32 by 32 bits.
				dh_s3[j] <= row_s2[j] * $signed(minor_s2[j][MINOR_W-1:32]);
				dl_s3[j] <= row_s2[j] * $signed({1'b0, minor_s2[j][31:0]});
			end
			for (int c = 0; c < 6; c++) begin
				gram_s2[c] <= B_W'(bp_s1[3*c]) + B_W'(bp_s1[3*c+1]) + B_W'(bp_s1[3*c+2]);
			end
			gram_s3 <= gram_s2;
			gram_s4 <= gram_s3;
			det_s4  <= det_nx;
		end
	end

	assign det  = det_s4;
	assign gram = gram_s4;

endmodule

`default_nettype wire

### src/nhs_log.sv
// ----------------------------------------------------------------------------
// nhs_log: natural logarithm of the determinant
// Normalises the determinant, takes 56 bits of log2 by repeated squaring
// (two stages per bit) and scales by ln 2 with rounding half up.
// ----------------------------------------------------------------------------
`default_nettype none

module nhs_log #(
	parameter int F_FRACTION_BITS = 28
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [nhs_pkg::D_W-1:0]  det,
	output logic signed [nhs_pkg::L_W-1:0]  ln_det
);
	import nhs_pkg::*;

	localparam int SQ_W = 2 * M_W;
	localparam int SH   = 120 - 2 * F_FRACTION_BITS;

	logic [E_W-1:0]        top_bit;
	logic [DMAG_W-1:0]     det_s1;
	logic [E_W-1:0]        e_s1;
	logic [DMAG_W-1:0]     norm;

	logic [M_W-1:0]        m_sq  [LOG_ITERS+1];
	logic [LOG_ITERS-1:0]  fr_sq [LOG_ITERS+1];
	logic [E_W-1:0]        e_sq  [LOG_ITERS+1];
	logic [61:0]           hh_pp [LOG_ITERS];
	logic [62:0]           hl_pp [LOG_ITERS];
	logic [63:0]           ll_pp [LOG_ITERS];
	logic [LOG_ITERS-1:0]  fr_pp [LOG_ITERS];
	logic [E_W-1:0]        e_pp  [LOG_ITERS];
	logic [SQ_W-1:0]       sq    [LOG_ITERS];
	logic [63:0]           tq    [LOG_ITERS];
	logic [M_W-1:0]        m_nx  [LOG_ITERS];

	logic signed [K_W-1:0] k_int;
	logic [59:0]           p_hh_s1, p_hl_s1, p_lh_s1, p_ll_s1;
	logic signed [K_W+32:0] k_h_s1, k_l_s1;
	logic signed [P_W-1:0] p_sum;
	logic signed [L_W-1:0] ln_s2;

	always_comb begin
		top_bit = '0;
		for (int i = 0; i < DMAG_W; i++) begin
			if (det[i]) begin
				top_bit = E_W'(i);
			end
		end
	end

	assign norm = det_s1 << (E_W'(DMAG_W - 1) - e_s1);

	// Squaring step: m*m back to one integer bit; a carry into bit one is a
	// log2 bit of one and halves the mantissa.
	always_comb begin
		for (int i = 0; i < LOG_ITERS; i++) begin
			sq[i]   = (SQ_W'(hh_pp[i]) << 64) + (SQ_W'(hl_pp[i]) << 33) + SQ_W'(ll_pp[i]);
			tq[i]   = sq[i][SQ_W-1:62];
			m_nx[i] = tq[i][63] ? tq[i][63:1] : tq[i][62:0];
		end
	end

	assign k_int = K_W'($signed({1'b0, e_sq[LOG_ITERS]})) - K_W'(3 * F_FRACTION_BITS);

	always_comb begin
		p_sum = (P_W'(k_h_s1) <<< 88) + (P_W'(k_l_s1) <<< 56)
			+ $signed((P_W'(p_hh_s1) << 60) + (P_W'(p_hl_s1) << 28)
			+ (P_W'(p_lh_s1) << 32) + P_W'(p_ll_s1) + (P_W'(1) << (SH - 1)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s1   <= det[DMAG_W-1:0];
			e_s1     <= top_bit;
			m_sq[0]  <= norm[DMAG_W-1 -: M_W];
			fr_sq[0] <= '0;
			e_sq[0]  <= e_s1;
			for (int i = 0; i < LOG_ITERS; i++) begin
				hh_pp[i]   <= m_sq[i][M_W-1:32] * m_sq[i][M_W-1:32];
				hl_pp[i]   <= m_sq[i][M_W-1:32] * m_sq[i][31:0];
				ll_pp[i]   <= m_sq[i][31:0] * m_sq[i][31:0];
				fr_pp[i]   <= fr_sq[i];
				e_pp[i]    <= e_sq[i];
				m_sq[i+1]  <= m_nx[i];
				fr_sq[i+1] <= {fr_pp[i][LOG_ITERS-2:0], tq[i][63]};
				e_sq[i+1]  <= e_pp[i];
			end
			p_hh_s1 <= fr_sq[LOG_ITERS][55:28] * LN2_Q64[63:32];
			p_hl_s1 <= fr_sq[LOG_ITERS][55:28] * LN2_Q64[31:0];
			p_lh_s1 <= fr_sq[LOG_ITERS][27:0] * LN2_Q64[63:32];
			p_ll_s1 <= fr_sq[LOG_ITERS][27:0] * LN2_Q64[31:0];
			k_h_s1  <= k_int * $signed({1'b0, LN2_Q64[63:32]});
			k_l_s1  <= k_int * $signed({1'b0, LN2_Q64[31:0]});
			ln_s2   <= L_W'(p_sum >>> SH);
		end
	end

	assign ln_det = ln_s2;

endmodule

`default_nettype wire

### src/nhs_div.sv
// ----------------------------------------------------------------------------
// nhs_div: scaled, rounded and saturated quotient
// An overflow check against the upper part of the scaled magnitude, then a
// restoring divider with one quotient bit per stage, then rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module nhs_div #(
	parameter int F_FRACTION_BITS = 28
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [nhs_pkg::N_W-1:0]    num,
	input  logic signed [nhs_pkg::D_W-1:0]    den,
	output logic signed [nhs_pkg::SIG_W-1:0]  quo
);
	import nhs_pkg::*;

	localparam int SHIFT = F_FRACTION_BITS + SIG_FRAC;
	localparam int MAG_W = N_W + SHIFT;
	localparam int HI_W  = MAG_W - SIG_W;
	localparam int CMP_W = (HI_W > D_W) ? HI_W : D_W;
	localparam int R_W   = D_W;

	logic [N_W-1:0]   abs_n;
	logic [MAG_W-1:0] mag;
	logic             ovf;

	logic [R_W-1:0]   r_st   [SIG_W+1];
	logic [SIG_W-1:0] lo_st  [SIG_W+1];
	logic [SIG_W-1:0] q_st   [SIG_W+1];
	logic [D_W-1:0]   den_st [SIG_W+1];
	logic             neg_st [SIG_W+1];
	logic             ovf_st [SIG_W+1];
	logic [R_W-1:0]   r2 [SIG_W];
	logic             ge [SIG_W];

	logic             up;
	logic [SIG_W:0]   qr;
	logic             big;

	always_comb begin
		abs_n = num[N_W-1] ? N_W'(-num) : N_W'(num);
		mag   = {abs_n, {SHIFT{1'b0}}};
		ovf   = CMP_W'(mag[MAG_W-1:SIG_W]) >= CMP_W'($unsigned(den));
	end

	always_comb begin
		for (int j = 0; j < SIG_W; j++) begin
			r2[j] = {r_st[j][R_W-2:0], lo_st[j][SIG_W-1]};
			ge[j] = r2[j] >= den_st[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_st[0]   <= R_W'(mag[MAG_W-1:SIG_W]);
			lo_st[0]  <= mag[SIG_W-1:0];
			q_st[0]   <= '0;
			den_st[0] <= den;
			neg_st[0] <= num[N_W-1];
			ovf_st[0] <= ovf;
			for (int j = 0; j < SIG_W; j++) begin
				r_st[j+1]   <= ge[j] ? r2[j] - den_st[j] : r2[j];
				lo_st[j+1]  <= lo_st[j] << 1;
				q_st[j+1]   <= {q_st[j][SIG_W-2:0], ge[j]};
				den_st[j+1] <= den_st[j];
				neg_st[j+1] <= neg_st[j];
				ovf_st[j+1] <= ovf_st[j];
			end
		end
	end

	// Round to nearest with ties away from zero, then saturate on the sign.
	always_comb begin
		up  = {r_st[SIG_W][R_W-2:0], 1'b0} >= den_st[SIG_W];
		qr  = {1'b0, q_st[SIG_W]} + (SIG_W+1)'(up);
		big = ovf_st[SIG_W] | qr[SIG_W] | qr[SIG_W-1];
		if (big) begin
			quo = neg_st[SIG_W] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
		end else begin
			quo = neg_st[SIG_W] ? -$signed(qr[SIG_W-1:0]) : $signed(qr[SIG_W-1:0]);
		end
	end

endmodule

`default_nettype wire

### src/neo_hookean_stress.sv
// ----------------------------------------------------------------------------
// neo_hookean_stress: compressible neo-Hookean Cauchy stress pipeline
// Throughput: one word per cycle; a stalled output holds every stage.
// The pipeline length is set by the logarithm (two stages per log2 bit, 56 bits) and
// the divider (one stage per quotient bit, 64 bits).
// Reset clears the valid bits and both Lame registers; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module neo_hookean_stress #(
	parameter int F_FRACTION_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  nhs_pkg::in_word_t             item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output nhs_pkg::out_word_t            result,
	input  logic                          cfg_we,
	input  nhs_pkg::cfg_reg_t             cfg_index,
	input  logic [nhs_pkg::CFG_W-1:0]     cfg_data
);
	import nhs_pkg::*;

	localparam int BH_W = B_W - 2 * CH_W;
	localparam int LH_W = L_W - 2 * CH_W;

	logic [CFG_W-1:0]       lambda_q, mu_q;
	logic                   adv;
	logic [PIPE_LAT-1:0]    vld_s;

	logic signed [D_W-1:0]  g_det;
	gram_t                  g_gram;
	logic                   g_inv;
	side_t                  side_s [LOG_LAT];
	logic signed [L_W-1:0]  ln_det;

	logic signed [B_W-1:0]  xb [6];
	logic signed [CFG_W:0]  mu_x, lam_x;
	logic signed [CFG_W+CH_W+1:0] pm_lo_s1 [6];
	logic signed [CFG_W+CH_W+1:0] pm_mid_s1 [6];
	logic signed [CFG_W+BH_W:0]   pm_hi_s1 [6];
	logic signed [CFG_W+CH_W+1:0] pl_lo_s1, pl_mid_s1;
	logic signed [CFG_W+LH_W:0]   pl_hi_s1;
	logic [D_W-1:0]         det_s1, det_s2;
	logic                   inv_s1, inv_s2;
	logic signed [N_W-1:0]  lam_part;
	logic signed [N_W-1:0]  num_nx [6];
	logic signed [N_W-1:0]  num_s2 [6];

	logic                   inv_dv [DIV_LAT];
	logic signed [SIG_W-1:0] quo [6];
	out_word_t              res_nx, result_q;

	assign adv        = !vld_s[PIPE_LAT-1] || result_ready;
	assign item_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= '0;
			mu_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LAMBDA: lambda_q <= cfg_data;
				CFG_MU:     mu_q     <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], item_valid};
		end
	end

	nhs_gram u_gram (
		.clk  (clk),
		.en   (adv),
		.f    (item),
		.det  (g_det),
		.gram (g_gram)
	);

	assign g_inv = g_det[D_W-1] || (g_det == '0);

	nhs_log #(
		.F_FRACTION_BITS (F_FRACTION_BITS)
	) u_log (
		.clk    (clk),
		.en     (adv),
		.det    (g_det),
		.ln_det (ln_det)
	);

	// B and the determinant wait here while the logarithm is formed.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= '{det: g_det, gram: g_gram, inv: g_inv};
			for (int i = 1; i < LOG_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign mu_x  = $signed({1'b0, mu_q});
	assign lam_x = $signed({1'b0, lambda_q});

	always_comb begin
		for (int c = 0; c < 6; c++) begin
			if (c < 3) begin
				xb[c] = $signed(side_s[LOG_LAT-1].gram[c])
					- (B_W'(1) <<< (2 * F_FRACTION_BITS));
			end else begin
				xb[c] = $signed(side_s[LOG_LAT-1].gram[c]);
			end
		end
	end

	always_comb begin
		lam_part = (N_W'(pl_hi_s1) <<< (2 * CH_W)) + (N_W'(pl_mid_s1) <<< CH_W)
			+ N_W'(pl_lo_s1);
		for (int c = 0; c < 6; c++) begin
			num_nx[c] = (N_W'(pm_hi_s1[c]) <<< (2 * CH_W)) + (N_W'(pm_mid_s1[c]) <<< CH_W)
				+ N_W'(pm_lo_s1[c]);
			if (c < 3) begin
				num_nx[c] = num_nx[c] + lam_part;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 6; c++) begin
				pm_lo_s1[c]  <= mu_x * $signed({1'b0, xb[c][CH_W-1:0]});
				pm_mid_s1[c] <= mu_x * $signed({1'b0, xb[c][2*CH_W-1:CH_W]});
				pm_hi_s1[c]  <= mu_x * $signed(xb[c][B_W-1:2*CH_W]);
				num_s2[c]    <= num_nx[c];
			end
			pl_lo_s1  <= lam_x * $signed({1'b0, ln_det[CH_W-1:0]});
			pl_mid_s1 <= lam_x * $signed({1'b0, ln_det[2*CH_W-1:CH_W]});
			pl_hi_s1  <= lam_x * $signed(ln_det[L_W-1:2*CH_W]);
			det_s1    <= side_s[LOG_LAT-1].det;
			inv_s1    <= side_s[LOG_LAT-1].inv;
			det_s2    <= det_s1;
			inv_s2    <= inv_s1;
			inv_dv[0] <= inv_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				inv_dv[i] <= inv_dv[i-1];
			end
			result_q  <= res_nx;
		end
	end

	for (genvar c = 0; c < 6; c++) begin : g_div
		nhs_div #(
			.F_FRACTION_BITS (F_FRACTION_BITS)
		) u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s2[c]),
			.den ($signed(det_s2)),
			.quo (quo[c])
		);
	end

	always_comb begin
		res_nx.sigma_xx         = inv_dv[DIV_LAT-1] ? '0 : quo[0];
		res_nx.sigma_yy         = inv_dv[DIV_LAT-1] ? '0 : quo[1];
		res_nx.sigma_zz         = inv_dv[DIV_LAT-1] ? '0 : quo[2];
		res_nx.sigma_xy         = inv_dv[DIV_LAT-1] ? '0 : quo[3];
		res_nx.sigma_xz         = inv_dv[DIV_LAT-1] ? '0 : quo[4];
		res_nx.sigma_yz         = inv_dv[DIV_LAT-1] ? '0 : quo[5];
		res_nx.invalid_jacobian = inv_dv[DIV_LAT-1];
	end

	assign result_valid = vld_s[PIPE_LAT-1];
	assign result       = result_q;

endmodule

`default_nettype wire

### test/neo_hookean_stress_test.sv
// ----------------------------------------------------------------------------
// neo_hookean_stress_test: self-checking bench for the neo-Hookean stress unit
// Deformation gradient words are queued by a stimulus process and driven by a
// clocked driver. The bench predicts each stress word with wide integer
// arithmetic and checks the output stream in order under several Lame settings
// and flow-control patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module neo_hookean_stress_test;
	import nhs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB         = 28;
	localparam int ONE_F      = 1 << FB;
	localparam int WATCH_MAX  = 6000;
	localparam int HOLD_LEN   = 700;
	localparam int DRAIN_WAIT = 250;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_word_t  item;
	logic      result_valid;
	logic      result_ready;
	out_word_t result;
	logic      cfg_we;
	cfg_reg_t  cfg_index;
	logic [CFG_W-1:0] cfg_data;

	neo_hookean_stress u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	in_word_t  gradient_q[$];
	out_word_t stress_q[$];
	logic [31:0] lambda_now, mu_now;
	int  send_idle_pct, recv_stall_pct, hold_left;
	bit  word_taken;
	int  mismatches, words_in, words_out, invalid_seen, saturated_seen, quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Rounded, saturated num * 2^(FB+16) / den.
	function automatic logic [63:0] scaled_div(logic signed [255:0] num, logic [255:0] den);
		logic [255:0] mag, quo, rem;
		bit neg;
		neg = num < 0;
		mag = (neg ? -num : num);
		mag = mag << (FB + SIG_FRAC);
		quo = mag / den;
		rem = mag % den;
		if ((rem << 1) >= den)
			quo = quo + 1;
		if (quo >= (256'd1 << 63))
			return neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
		return neg ? -quo[63:0] : quo[63:0];
	endfunction

	function automatic out_word_t stress_of(in_word_t w);
		logic signed [255:0] f[9];
		logic signed [255:0] det, lg, prod, ln_j, gram, num, mu_w, lam_w, one_w;
		logic [63:0]  mant, frac;
		logic [127:0] sq;
		logic [63:0]  comp[6];
		int top, kexp, r, c;
		int rows[6];
		int cols[6];
		out_word_t o;
		rows = '{0, 1, 2, 0, 0, 1};
		cols = '{0, 1, 2, 1, 2, 2};
		f[0] = w.f_xx; f[1] = w.f_xy; f[2] = w.f_xz;
		f[3] = w.f_yx; f[4] = w.f_yy; f[5] = w.f_yz;
		f[6] = w.f_zx; f[7] = w.f_zy; f[8] = w.f_zz;
		det = f[0] * (f[4] * f[8] - f[5] * f[7]) - f[1] * (f[3] * f[8] - f[5] * f[6])
			+ f[2] * (f[3] * f[7] - f[4] * f[6]);
		o = '0;
		if (det <= 0) begin
			o.invalid_jacobian = 1'b1;
			return o;
		end
		top = 0;
		for (int i = 0; i < 256; i++)
			if (det[i]) top = i;
		mant = (top >= 62) ? 64'(det >> (top - 62)) : 64'(det << (62 - top));
		frac = '0;
		for (int i = 0; i < 56; i++) begin
			sq = {64'd0, mant} * {64'd0, mant};
			mant = 64'(sq >> 62);
			frac = frac << 1;
			if (mant[63]) begin
				frac[0] = 1'b1;
				mant = mant >> 1;
			end
		end
		kexp = top - 3 * FB;
		lg = kexp;
		lg = (lg <<< 56) + $signed({192'd0, frac});
		prod = lg * $signed({192'd0, LN2_Q64});
		prod = prod + (256'sd1 <<< 63);
		ln_j = prod >>> (120 - 2 * FB);
		mu_w = $signed({224'd0, mu_now});
		lam_w = $signed({224'd0, lambda_now});
		one_w = 256'sd1 <<< (2 * FB);
		for (int k = 0; k < 6; k++) begin
			r = rows[k];
			c = cols[k];
			gram = f[r*3] * f[c*3] + f[r*3+1] * f[c*3+1] + f[r*3+2] * f[c*3+2];
			num = (k < 3) ? mu_w * (gram - one_w) + lam_w * ln_j : mu_w * gram;
			comp[k] = scaled_div(num, $unsigned(det));
		end
		o.sigma_xx = comp[0]; o.sigma_yy = comp[1]; o.sigma_zz = comp[2];
		o.sigma_xy = comp[3]; o.sigma_xz = comp[4]; o.sigma_yz = comp[5];
		return o;
	endfunction

	function automatic in_word_t gradient(int a, int b, int c, int d, int e, int f,
			int g, int h, int i);
		in_word_t w;
		w.f_xx = a; w.f_xy = b; w.f_xz = c;
		w.f_yx = d; w.f_yy = e; w.f_yz = f;
		w.f_zx = g; w.f_zy = h; w.f_zz = i;
		return w;
	endfunction

	function automatic int perturb(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Mostly physical gradients near a scaled identity, with some raw noise,
	// inverted and singular ones mixed in.
	function automatic in_word_t random_gradient();
		in_word_t w;
		int sel, span, scale;
		sel = $urandom_range(99);
		if (sel < 70) begin
			span = 1 << $urandom_range(27, 4);
			scale = (sel < 10) ? int'($urandom_range(ONE_F * 7, 1 << 20)) : ONE_F;
			w = gradient(scale + perturb(span), perturb(span), perturb(span),
				perturb(span), scale + perturb(span), perturb(span),
				perturb(span), perturb(span), scale + perturb(span));
		end else if (sel < 85) begin
			w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom};
		end else if (sel < 95) begin
			span = 1 << $urandom_range(26, 4);
			w = gradient(-ONE_F + perturb(span), perturb(span), perturb(span),
				perturb(span), ONE_F + perturb(span), perturb(span),
				perturb(span), perturb(span), ONE_F + perturb(span));
		end else begin
			w.f_xx = $urandom; w.f_xy = $urandom; w.f_xz = $urandom;
			w.f_yx = w.f_xx;   w.f_yy = w.f_xy;   w.f_yz = w.f_xz;
			w.f_zx = $urandom; w.f_zy = $urandom; w.f_zz = $urandom;
		end
		return w;
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || word_taken) begin
			if (gradient_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item       <= gradient_q.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left    = hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		logic [63:0] w_f[7];
		logic [63:0] g_f[7];
		string names[7];
		bit bad;
		word_taken = item_valid && item_ready && arst_n;
		if (word_taken) begin
			stress_q.push_back(stress_of(item));
			words_in++;
		end
		if (arst_n && result_valid && result_ready) begin
			words_out++;
			if (result.invalid_jacobian)
				invalid_seen++;
			if (result.sigma_xx == 64'h7FFFFFFFFFFFFFFF || result.sigma_xx == 64'h8000000000000000)
				saturated_seen++;
			if (stress_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected stress word %h", result);
			end else begin
				want = stress_q.pop_front();
				names = '{"sigma_xx", "sigma_yy", "sigma_zz", "sigma_xy", "sigma_xz",
					"sigma_yz", "invalid_jacobian"};
				w_f = '{want.sigma_xx, want.sigma_yy, want.sigma_zz, want.sigma_xy,
					want.sigma_xz, want.sigma_yz, 64'(want.invalid_jacobian)};
				g_f = '{result.sigma_xx, result.sigma_yy, result.sigma_zz, result.sigma_xy,
					result.sigma_xz, result.sigma_yz, 64'(result.invalid_jacobian)};
				bad = 1'b0;
				for (int k = 0; k < 7; k++)
					if (w_f[k] !== g_f[k])
						bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						for (int k = 0; k < 7; k++)
							if (w_f[k] !== g_f[k])
								$display("word %0d %s: expected %h, got %h",
									words_out, names[k], w_f[k], g_f[k]);
				end
			end
		end
		if (word_taken || (result_valid && result_ready) || (gradient_q.size() == 0
				&& stress_q.size() == 0 && !item_valid))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCH_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LAMBDA)
			lambda_now = val;
		else
			mu_now = val;
	endtask

	task automatic drain();
		while (gradient_q.size() > 0 || stress_q.size() > 0 || item_valid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(logic [31:0] lam, logic [31:0] mu, int send_pct, int recv_pct,
			int count);
		write_reg(CFG_LAMBDA, lam);
		write_reg(CFG_MU, mu);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int n = 0; n < count; n++)
			gradient_q.push_back(random_gradient());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LAMBDA;
		cfg_data = '0;
		lambda_now = '0;
		mu_now = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		word_taken = 1'b0;
		mismatches = 0;
		words_in = 0;
		words_out = 0;
		invalid_seen = 0;
		saturated_seen = 0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words under zero registers, then a realistic material, then both registers at their maximum.
		gradient_q.push_back(gradient(ONE_F, 0, 0, 0, ONE_F, 0, 0, 0, ONE_F));
		drain();
		write_reg(CFG_LAMBDA, 32'd2000000000);
		write_reg(CFG_MU, 32'd800000000);
		gradient_q.push_back(gradient(ONE_F, 0, 0, 0, ONE_F, 0, 0, 0, ONE_F));
		gradient_q.push_back(gradient(0, 0, 0, 0, 0, 0, 0, 0, 0));
		gradient_q.push_back(gradient(-ONE_F, 0, 0, 0, ONE_F, 0, 0, 0, ONE_F));
		gradient_q.push_back(gradient(ONE_F, ONE_F, 0, ONE_F, ONE_F, 0, 0, 0, ONE_F));
		gradient_q.push_back(gradient(1, 0, 0, 0, 1, 0, 0, 0, 1));
		gradient_q.push_back(gradient(1, 0, 0, 0, 1, 0, 0, 0, 32'h7FFFFFFF));
		gradient_q.push_back(gradient(32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0,
			32'h7FFFFFFF));
		gradient_q.push_back(gradient(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0,
			32'h80000000));
		gradient_q.push_back(gradient(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0,
			32'h7FFFFFFF));
		gradient_q.push_back(gradient(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF));
		gradient_q.push_back(gradient(ONE_F / 2, 0, 0, 0, ONE_F * 2, 0, 0, 0, ONE_F));
		gradient_q.push_back(gradient(ONE_F, ONE_F / 4, -ONE_F / 8, ONE_F / 3, ONE_F,
			ONE_F / 5, -ONE_F / 7, ONE_F / 6, ONE_F));
		gradient_q.push_back(gradient(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		gradient_q.push_back(gradient(0, ONE_F, 0, 0, 0, ONE_F, ONE_F, 0, 0));
		drain();
		write_reg(CFG_LAMBDA, 32'hFFFFFFFF);
		write_reg(CFG_MU, 32'hFFFFFFFF);
		gradient_q.push_back(gradient(1, 0, 0, 0, 1, 0, 0, 0, 1));
		gradient_q.push_back(gradient(32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0,
			32'h7FFFFFFF));
		gradient_q.push_back(gradient(ONE_F, 0, 0, 0, ONE_F, 0, 0, 0, ONE_F));
		gradient_q.push_back(gradient(2, 32'h7FFFFFFF, 0, 0, 1, 0, 0, 0, 1));
		drain();

		run_phase(32'd2000000000, 32'd800000000, 0, 0, 250);
		run_phase(32'd0, 32'd0, 66, 0, 200);

		// Long output hold-off while words keep arriving, so the pipe backs up.
		// The registers are set before any of these words is offered.
		write_reg(CFG_LAMBDA, 32'hFFFFFFFF);
		write_reg(CFG_MU, 32'hFFFFFFFF);
		send_idle_pct  = 0;
		recv_stall_pct = 66;
		hold_left = HOLD_LEN;
		for (int n = 0; n < 300; n++)
			gradient_q.push_back(random_gradient());
		drain();
		run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 66, 150);
		run_phase($urandom, $urandom, 18, 18, 200);
		run_phase(32'hFFFFFFFF, 32'd0, 0, 0, 60);
		run_phase(32'd0, 32'hFFFFFFFF, 18, 18, 60);
		run_phase($urandom_range(100000000), $urandom_range(100000000), 0, 0, 30);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("checked %0d stress words from %0d gradients", words_out, words_in);
		$display("%0d inverted or singular, %0d saturated xx, %0d mismatches",
			invalid_seen, saturated_seen, mismatches);
		if (mismatches == 0 && stress_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
src/nhs_pkg.sv
src/nhs_gram.sv
src/nhs_log.sv
src/nhs_div.sv
src/neo_hookean_stress.sv
test/neo_hookean_stress_test.sv
